// ===== src/sliding_window_median_top_defines.svh =====
// Assertion macros shared by the sliding window median RTL.
// Users must have clk_i and rst_ni in scope; no other dependencies.
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("swm: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("swm: next-cycle check failed");

`endif

// ===== src/swm_pkg.sv =====
// Shared types and constants of the sliding window median block.
// No dependencies; imported by the interfaces, swm_ctrl, swm_datapath and the top level.
`default_nettype none

package swm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TOTAL_W  = 48;
  localparam int CFG_W    = 11;
  localparam logic [CFG_W-1:0] CFG_WIN_RESET = 11'd3;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RING,
    S_RMV_RD,
    S_RMV_WR,
    S_ADD_RD,
    S_ADD_WR,
    S_CHECK,
    S_DESC,
    S_DONE
  } swm_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic clr_start;
    logic clr_step;
    logic ring_rd;
    logic rmv_rd;
    logic rmv_wr;
    logic add_wr;
    logic desc_start;
    logic desc_step;
    logic out_load;
  } swm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic full;
    logic desc_last;
    logic out_full;
    logic cfg_wr;
  } swm_sts_t;

endpackage

`default_nettype wire

// ===== src/swm_req_if.sv =====
// Request channel of the sliding window median block: sample and restart.
// Depends on swm_pkg for the field widths.
`default_nettype none

interface swm_req_if
  import swm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

// ===== src/swm_res_if.sv =====
// Result channel of the sliding window median block: median and running total.
// Depends on swm_pkg for the field widths.
`default_nettype none

interface swm_res_if
  import swm_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] median;
  logic [TOTAL_W-1:0]  median_total;

  modport source (output valid, output median, output median_total, input ready);
  modport sink   (input valid, input median, input median_total, output ready);
endinterface

`default_nettype wire

// ===== src/swm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module swm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/swm_datapath.sv =====
// Datapath of the sliding window median: sample ring, per-level count RAMs of
// a binary count tree, rank descent, running total and output register.
// Depends on swm_pkg, swm_ram and the assertion macro header.
`default_nettype none
`include "sliding_window_median_top_defines.svh"

module swm_datapath
  import swm_pkg::*;
#(
  parameter int VALUE_BITS = 16,
  parameter int MAX_WINDOW = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CFG_W-1:0]    cfg_wdata_i,
  input  wire logic [SAMPLE_W-1:0] sample_i,
  input  wire swm_cmd_t            cmd_i,
  output swm_sts_t                 sts_o,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic      [SAMPLE_W-1:0] median_o,
  output logic      [TOTAL_W-1:0]  median_total_o
);

  localparam int WIN_W = $clog2(MAX_WINDOW + 1);
  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CMP_W = (WIN_W > CFG_W) ? WIN_W : CFG_W;
  localparam int LVL_W = $clog2(VALUE_BITS);

  logic [CFG_W-1:0]      win_q;
  logic [WIN_W-1:0]      w_eff;
  logic [WIN_W:0]        rank_sum;
  logic [WIN_W-1:0]      rank_w;
  logic [WIN_W-1:0]      fill_q, fill_d;
  logic [PTR_W-1:0]      ptr_q, ptr_d;
  logic [TOTAL_W-1:0]    sum_q, sum_d;
  logic [VALUE_BITS-1:0] clr_cnt_q, clr_cnt_d;
  logic [VALUE_BITS-1:0] smp_q;
  logic [PTR_W-1:0]      old_idx;
  logic [WIN_W-1:0]      ptr_ext, idx_diff;
  logic [VALUE_BITS-1:0] ring_rdata;
  logic [VALUE_BITS-1:0] upd_val;
  logic                  full;
  logic                  desc_mode;
  logic                  lvl_we;

  logic [WIN_W-1:0]      lvl_cnt [VALUE_BITS];
  logic [WIN_W-1:0]      cnt_sel;
  logic                  go_right;
  logic [VALUE_BITS-1:0] p_q, p_d;
  logic [WIN_W-1:0]      rank_q, rank_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;

  logic                  out_valid_q, out_valid_d;
  logic [SAMPLE_W-1:0]   med_q;
  logic [TOTAL_W-1:0]    total_q;

  // Window length as used: zero counts as one, long windows are clamped.
  always_comb begin
    if (win_q == '0) begin
      w_eff = WIN_W'(1);
    end else if (CMP_W'(win_q) > CMP_W'(MAX_WINDOW)) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = WIN_W'(win_q);
    end
  end

  assign rank_sum = (WIN_W + 1)'(w_eff) + (WIN_W + 1)'(1);
  assign rank_w   = rank_sum[WIN_W:1];
  assign full     = (fill_q >= w_eff);

  // Ring slot of the sample that leaves the window.
  assign ptr_ext = WIN_W'(ptr_q);
  always_comb begin
    if (ptr_ext >= w_eff) begin
      idx_diff = ptr_ext - w_eff;
    end else begin
      idx_diff = ptr_ext + WIN_W'(MAX_WINDOW) - w_eff;
    end
  end
  assign old_idx = idx_diff[PTR_W-1:0];

  swm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add_wr),
    .waddr_i (ptr_q),
    .wdata_i (smp_q),
    .re_i    (cmd_i.ring_rd),
    .raddr_i (old_idx),
    .rdata_o (ring_rdata)
  );

  assign upd_val   = (cmd_i.rmv_rd || cmd_i.rmv_wr) ? ring_rdata : smp_q;
  assign desc_mode = cmd_i.desc_start || cmd_i.desc_step;
  assign lvl_we    = cmd_i.clr_step || cmd_i.rmv_wr || cmd_i.add_wr;

  // Level l of the tree holds 2^l node counts; the leaves are level VALUE_BITS.
  for (genvar l = 1; l <= VALUE_BITS; l++) begin : g_lvl
    logic [l-1:0]     upd_addr;
    logic [l-1:0]     dsc_addr;
    logic [l-1:0]     rd_addr;
    logic [l-1:0]     wr_addr;
    logic [WIN_W-1:0] wr_data;

    assign upd_addr = upd_val[VALUE_BITS-1 -: l];
    if (l == 1) begin : g_top
      assign dsc_addr = 1'b0;
    end else begin : g_low
      assign dsc_addr = {p_d[l-2:0], 1'b0};
    end
    assign rd_addr = desc_mode ? dsc_addr : upd_addr;
    assign wr_addr = cmd_i.clr_step ? clr_cnt_q[l-1:0] : upd_addr;

    always_comb begin
      if (cmd_i.clr_step) begin
        wr_data = '0;
      end else if (cmd_i.rmv_wr) begin
        wr_data = lvl_cnt[l-1] - WIN_W'(1);
      end else begin
        wr_data = lvl_cnt[l-1] + WIN_W'(1);
      end
    end

    swm_ram #(
      .WIDTH (WIN_W),
      .DEPTH (2 ** l)
    ) u_cnt (
      .clk_i   (clk_i),
      .we_i    (lvl_we),
      .waddr_i (wr_addr),
      .wdata_i (wr_data),
      .re_i    (1'b1),
      .raddr_i (rd_addr),
      .rdata_o (lvl_cnt[l-1])
    );
  end

  // One level of the descent per cycle: compare the left child with the rank.
  assign cnt_sel  = lvl_cnt[lvl_q];
  assign go_right = (cnt_sel < rank_q);

  always_comb begin
    p_d    = p_q;
    rank_d = rank_q;
    lvl_d  = lvl_q;
    if (cmd_i.desc_start) begin
      p_d    = '0;
      rank_d = rank_w;
      lvl_d  = '0;
    end else if (cmd_i.desc_step) begin
      p_d   = {p_q[VALUE_BITS-2:0], go_right};
      lvl_d = lvl_q + LVL_W'(1);
      if (go_right) begin
        rank_d = rank_q - cnt_sel;
      end
    end
  end

  always_comb begin
    fill_d    = fill_q;
    ptr_d     = ptr_q;
    sum_d     = sum_q;
    clr_cnt_d = clr_cnt_q;
    if (cmd_i.clr_start) begin
      fill_d    = '0;
      ptr_d     = '0;
      sum_d     = '0;
      clr_cnt_d = '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_d = clr_cnt_q + VALUE_BITS'(1);
      end
      if (cmd_i.add_wr) begin
        if (!full) begin
          fill_d = fill_q + WIN_W'(1);
        end
        if (ptr_q == PTR_W'(MAX_WINDOW - 1)) begin
          ptr_d = '0;
        end else begin
          ptr_d = ptr_q + PTR_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        sum_d = sum_q + TOTAL_W'(p_q);
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= CFG_WIN_RESET;
      fill_q      <= '0;
      ptr_q       <= '0;
      sum_q       <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      fill_q      <= fill_d;
      ptr_q       <= ptr_d;
      sum_q       <= sum_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    rank_q <= rank_d;
    lvl_q  <= lvl_d;
    if (cmd_i.take) begin
      smp_q <= sample_i[VALUE_BITS-1:0];
    end
    if (cmd_i.out_load) begin
      med_q   <= SAMPLE_W'(p_q);
      total_q <= sum_d;
    end
  end

  assign sts_o.clr_last  = &clr_cnt_q;
  assign sts_o.full      = full;
  assign sts_o.desc_last = (lvl_q == LVL_W'(VALUE_BITS - 1));
  assign sts_o.out_full  = out_valid_q && !out_ready_i;
  assign sts_o.cfg_wr    = cfg_we_i;

  assign out_valid_o    = out_valid_q;
  assign median_o       = med_q;
  assign median_total_o = total_q;

  `SWM_ASSERT_IMP(a_fill_bound, 1'b1, fill_q <= w_eff)
  `SWM_ASSERT_IMP(a_rank_live, cmd_i.desc_step, rank_q != '0)
  `SWM_ASSERT_IMP(a_valid_src, $rose(out_valid_q), $past(cmd_i.out_load))

endmodule

`default_nettype wire

// ===== src/swm_ctrl.sv =====
// Controller state machine of the sliding window median block.
// Depends on swm_pkg and the assertion macro header.
`default_nettype none
`include "sliding_window_median_top_defines.svh"

module swm_ctrl
  import swm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  input  wire logic     in_restart_i,
  output logic          in_ready_o,
  input  wire swm_sts_t sts_i,
  output swm_cmd_t      cmd_o
);

  swm_state_e state_q, state_d;
  logic       pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          pend_d  = 1'b0;
          state_d = pend_q ? S_RING : S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (in_restart_i) begin
            cmd_o.clr_start = 1'b1;
            pend_d          = 1'b1;
            state_d         = S_CLEAR;
          end else begin
            state_d = S_RING;
          end
        end
      end
      S_RING: begin
        cmd_o.ring_rd = 1'b1;
        state_d       = sts_i.full ? S_RMV_RD : S_ADD_RD;
      end
      S_RMV_RD: begin
        cmd_o.rmv_rd = 1'b1;
        state_d      = S_RMV_WR;
      end
      S_RMV_WR: begin
        cmd_o.rmv_wr = 1'b1;
        state_d      = S_ADD_RD;
      end
      S_ADD_RD: begin
        state_d = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.full) begin
          cmd_o.desc_start = 1'b1;
          state_d          = S_DESC;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DESC: begin
        cmd_o.desc_step = 1'b1;
        if (sts_i.desc_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase

    // A register write restarts the window from scratch.
    if (sts_i.cfg_wr) begin
      cmd_o           = '0;
      cmd_o.clr_start = 1'b1;
      pend_d          = 1'b0;
      in_ready_o      = 1'b0;
      state_d         = S_CLEAR;
    end
  end

  `SWM_ASSERT_NXT(a_cfg_clears, sts_i.cfg_wr, state_q == S_CLEAR)
  `SWM_ASSERT_IMP(a_load_free, cmd_o.out_load, !sts_i.out_full)
  `SWM_ASSERT_IMP(a_ready_idle, in_ready_o, state_q == S_IDLE)

endmodule

`default_nettype wire

// ===== src/sliding_window_median_top.sv =====
// Top level of the sliding window median block.
// Depends on swm_pkg, swm_req_if, swm_res_if, swm_ctrl and swm_datapath.
//
// Usage. Samples arrive as requests on req_i (valid/ready); each request
// carries a sample and a restart flag. Only the low VALUE_BITS bits of the
// sample are used. Once the window holds window_length samples, every request
// yields one result on res_o: the lower median of the window and the running
// total of all medians since the last restart, modulo 2^48. While the window
// fills, requests yield no result.
// Timing. A request is taken in the idle state. A request that yields no result
// passes through ring read, count insertion and a check before the next one can
// be taken. With a full window a request passes through ring read, count removal,
// count insertion, the check, the tree descent and the result load; the request
// that first fills the window skips the count removal. The descent does one count
// RAM read per level; removal and insertion are read-modify-write passes over all
// levels. Reset, restart and a write of cfg_wdata_i zero every count RAM in a
// sweep, during which no request is taken; a restart request is then processed
// after the sweep. The register write also clears the window.
// Stalls. The result sits in an output register; the block keeps taking
// requests while it waits, and holds only when a second result is ready.
`default_nettype none

module sliding_window_median_top
  import swm_pkg::*;
#(
  parameter int VALUE_BITS = 16,
  parameter int MAX_WINDOW = 1024
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i,
  swm_req_if.sink               req_i,
  swm_res_if.source             res_o
);

  swm_cmd_t cmd;
  swm_sts_t sts;

  // The controller sequences ring read, count removal, count insertion,
  // descent and result load; the datapath owns every memory and every data register.
  swm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (req_i.valid),
    .in_restart_i (req_i.restart),
    .in_ready_o   (req_i.ready),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  swm_datapath #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .sample_i       (req_i.sample),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_ready_i    (res_o.ready),
    .out_valid_o    (res_o.valid),
    .median_o       (res_o.median),
    .median_total_o (res_o.median_total)
  );

endmodule

`default_nettype wire
